@@ rtl/core/espm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espm_pkg
// Shared types, register indexes, function codes and constants of the
// epipolar SAD patch matcher.
// ----------------------------------------------------------------------------
package espm_pkg;

  localparam int unsigned MAX_COLS_D        = 512;
  localparam int unsigned MAX_ROWS_D        = 512;
  localparam int unsigned MAX_HALF_WINDOW_D = 16;
  localparam int unsigned PIXEL_CHANNELS_D  = 3;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned SAD_W  = 20;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned COEF_W = 32;

  localparam logic [SAD_W-1:0] NONE_MARK = 20'hFFFFF;
  localparam logic [SAD_W-1:0] SAD_CAP   = 20'hFFFFE;

  // function codes of an input word
  typedef enum logic [1:0] {
    FUNC_WR_LEFT  = 2'd0,
    FUNC_WR_RIGHT = 2'd1,
    FUNC_QUERY    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LEFT_WIDTH   = 3'd0,
    REG_LEFT_HEIGHT  = 3'd1,
    REG_RIGHT_WIDTH  = 3'd2,
    REG_RIGHT_HEIGHT = 3'd3,
    REG_HALF_WINDOW  = 3'd4,
    REG_RATIO        = 3'd5,
    REG_CHANNELS     = 3'd6,
    REG_SPARE        = 3'd7
  } reg_idx_t;

  localparam logic [9:0]  RST_SIZE     = 10'd512;
  localparam logic [4:0]  RST_HALF_WIN = 5'd5;
  localparam logic [15:0] RST_RATIO    = 16'd52429;
  localparam logic [1:0]  RST_CHANNELS = 2'd1;

endpackage
`default_nettype wire

@@ rtl/core/espm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espm_ram
// Image store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module espm_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/espm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module espm_div #(
  parameter int unsigned DW = 44
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [31:0]   divisor,
  output logic               done_r,
  output logic [DW-1:0]      quot_r
);
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [32:0]      rem_r, rem_nxt, rem_sh;
  logic [31:0]      dvs_r;
  logic [DW-1:0]    quot_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  // one shift and trial subtract
  always_comb begin
    rem_sh   = {rem_r[31:0], quot_r[DW-1]};
    quot_nxt = {quot_r[DW-2:0], 1'b0};
    rem_nxt  = rem_sh;
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt     = rem_sh - {1'b0, dvs_r};
      quot_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        rem_r  <= '0;
        dvs_r  <= divisor;
        quot_r <= dividend;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/epipolar_sad_patch_matcher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// epipolar_sad_patch_matcher
// Stereo patch matcher along an epipolar line with a ratio test.
// ----------------------------------------------------------------------------
// A pixel write is taken whenever the block is idle. For a query, every column
// runs the serial divider, with a dividend width DW of 34 + clog2(MAX_COLS+1)
// (44 by default), for its line row, and every candidate window reads one
// pixel pair per cycle from the two image stores. One query is in work at a
// time; pixel writes are taken while a finished result waits on the output.
// ----------------------------------------------------------------------------
module epipolar_sad_patch_matcher
  import espm_pkg::*;
#(
  parameter int unsigned MAX_COLS        = MAX_COLS_D,
  parameter int unsigned MAX_ROWS        = MAX_ROWS_D,
  parameter int unsigned MAX_HALF_WINDOW = MAX_HALF_WINDOW_D,
  parameter int unsigned PIXEL_CHANNELS  = PIXEL_CHANNELS_D
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [espm_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [espm_pkg::POS_W-1:0]   in_pixel_col,
  input  wire logic [espm_pkg::POS_W-1:0]   in_pixel_row,
  input  wire logic [espm_pkg::PIX_W-1:0]   in_pixel_value,
  input  wire logic [espm_pkg::POS_W-1:0]   in_query_col,
  input  wire logic [espm_pkg::POS_W-1:0]   in_query_row,
  input  wire logic signed [31:0]           in_line_a,
  input  wire logic signed [31:0]           in_line_b,
  input  wire logic signed [31:0]           in_line_c,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_found,
  output logic [espm_pkg::POS_W-1:0]        out_ref_col,
  output logic [espm_pkg::POS_W-1:0]        out_ref_row,
  output logic [espm_pkg::POS_W-1:0]        out_match_col,
  output logic [espm_pkg::POS_W-1:0]        out_match_row,
  output logic [espm_pkg::SAD_W-1:0]        out_best_sad,
  output logic [espm_pkg::SAD_W-1:0]        out_second_sad
);
  import espm_pkg::*;

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned WW    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned IW    = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int unsigned HW    = $clog2(PIXEL_CHANNELS + 1);
  localparam int unsigned DW    = 34 + CW;
  localparam int unsigned SW    =
    $clog2(4 * MAX_HALF_WINDOW * MAX_HALF_WINDOW * PIXEL_CHANNELS * 255 + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NUM, S_DIV, S_CHK, S_SAD, S_DRAIN, S_UPD, S_NEXT, S_FIN,
    S_OUT
  } state_t;

  // configuration registers
  logic [9:0]  lw_cfg_r, lh_cfg_r, rw_cfg_r, rh_cfg_r;
  logic [4:0]  hw_cfg_r;
  logic [15:0] ratio_r;
  logic [1:0]  ch_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_cfg_r <= RST_SIZE;
      lh_cfg_r <= RST_SIZE;
      rw_cfg_r <= RST_SIZE;
      rh_cfg_r <= RST_SIZE;
      hw_cfg_r <= RST_HALF_WIN;
      ratio_r  <= RST_RATIO;
      ch_cfg_r <= RST_CHANNELS;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_WIDTH:   lw_cfg_r <= cfg_wdata[9:0];
        REG_LEFT_HEIGHT:  lh_cfg_r <= cfg_wdata[9:0];
        REG_RIGHT_WIDTH:  rw_cfg_r <= cfg_wdata[9:0];
        REG_RIGHT_HEIGHT: rh_cfg_r <= cfg_wdata[9:0];
        REG_HALF_WINDOW:  hw_cfg_r <= cfg_wdata[4:0];
        REG_RATIO:        ratio_r  <= cfg_wdata;
        REG_CHANNELS:     ch_cfg_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // saturate sizes, window and channel count
  logic [WW-1:0] w_eff;
  logic [HW-1:0] ch_eff;
  logic [CW-1:0] lw_eff, rw_eff;
  logic [RW-1:0] lh_eff, rh_eff;

  always_comb begin
    if (hw_cfg_r == 5'd0) w_eff = WW'(1);
    else if (32'(hw_cfg_r) > MAX_HALF_WINDOW) w_eff = WW'(MAX_HALF_WINDOW);
    else w_eff = WW'(hw_cfg_r);
    if (ch_cfg_r == 2'd0) ch_eff = HW'(1);
    else if (32'(ch_cfg_r) > PIXEL_CHANNELS) ch_eff = HW'(PIXEL_CHANNELS);
    else ch_eff = HW'(ch_cfg_r);
    lw_eff = (32'(lw_cfg_r) > MAX_COLS) ? CW'(MAX_COLS) : CW'(lw_cfg_r);
    rw_eff = (32'(rw_cfg_r) > MAX_COLS) ? CW'(MAX_COLS) : CW'(rw_cfg_r);
    lh_eff = (32'(lh_cfg_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(lh_cfg_r);
    rh_eff = (32'(rh_cfg_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rh_cfg_r);
  end

  // query state
  state_t               state_r;
  logic [POS_W-1:0]     qc_r, qr_r;
  logic signed [31:0]   a_r, b_r, c_r;
  logic [CW-1:0]        x_r;
  logic [RW-1:0]        y_r;
  logic signed [DW-1:0] prod_r, num_r;
  logic                 neg_r;
  logic [IW-1:0]        i_r, j_r;
  logic                 rd_v_r;
  logic [SW-1:0]        acc_r;
  logic [SAD_W-1:0]     best_r, second_r;
  logic [POS_W-1:0]     bcol_r, brow_r;
  logic [1:0]           cnt_r;
  logic                 div_start;
  logic                 div_done;
  logic [DW-1:0]        div_q;

  // input handshake
  logic  in_acc;
  func_t func;
  assign func     = func_t'(in_func);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // store writes
  logic          pix_in;
  logic [AW-1:0] wr_addr;
  assign pix_in  = (32'(in_pixel_col) < MAX_COLS) && (32'(in_pixel_row) < MAX_ROWS);
  assign wr_addr = AW'(32'(in_pixel_row) * MAX_COLS + 32'(in_pixel_col));

  // window read addresses
  logic [AW-1:0]    l_addr, r_addr;
  logic [PIX_W-1:0] l_pix, r_pix;
  logic [IW-1:0]    two_w;
  assign two_w  = IW'({w_eff, 1'b0});
  assign l_addr = AW'((32'(qr_r) - 32'(w_eff) + 32'(i_r)) * MAX_COLS
                      + 32'(qc_r) - 32'(w_eff) + 32'(j_r));
  assign r_addr = AW'((32'(y_r) - 32'(w_eff) + 32'(i_r)) * MAX_COLS
                      + 32'(x_r) - 32'(w_eff) + 32'(j_r));

  espm_ram #(.DEPTH(DEPTH), .WIDTH(PIX_W)) u_left (
    .clk(clk), .wr_en(in_acc && func == FUNC_WR_LEFT && pix_in),
    .wr_addr(wr_addr), .wr_data(in_pixel_value),
    .rd_addr(l_addr), .rd_data_r(l_pix)
  );

  espm_ram #(.DEPTH(DEPTH), .WIDTH(PIX_W)) u_right (
    .clk(clk), .wr_en(in_acc && func == FUNC_WR_RIGHT && pix_in),
    .wr_addr(wr_addr), .wr_data(in_pixel_value),
    .rd_addr(r_addr), .rd_data_r(r_pix)
  );

  // line row divider, fed with the magnitude of a*x + c as it is formed
  logic signed [DW-1:0] num_sum;
  logic [DW-1:0]        num_mag;
  logic [31:0]          b_mag;
  assign num_sum = prod_r + DW'(c_r);
  assign num_mag = num_sum[DW-1] ? DW'(-num_sum) : DW'(num_sum);
  assign b_mag   = b_r[31] ? 32'(-b_r) : 32'(b_r);

  espm_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(num_mag), .divisor(b_mag),
    .done_r(div_done), .quot_r(div_q)
  );
  assign div_start = (state_r == S_NUM);

  // absolute differences of one pixel pair
  logic [SW-1:0] pair_sum;
  always_comb begin
    logic [7:0] p, q;
    pair_sum = '0;
    for (int k = 0; k < PIXEL_CHANNELS; k++) begin
      p = l_pix[8*k +: 8];
      q = r_pix[8*k +: 8];
      if (HW'(k) < ch_eff) begin
        pair_sum = pair_sum + SW'((p > q) ? p - q : q - p);
      end
    end
  end

  // candidate checks
  logic          y_ok, win_ok, start_ok;
  logic [SAD_W-1:0] d_sat;
  assign y_ok   = !(neg_r && div_q != '0) && (div_q < DW'(rh_eff));
  assign win_ok = (32'(x_r) >= 32'(w_eff)) && (32'(div_q[RW-1:0]) >= 32'(w_eff))
               && (32'(x_r) + 32'(w_eff) <= 32'(rw_eff))
               && (32'(div_q[RW-1:0]) + 32'(w_eff) <= 32'(rh_eff));
  assign start_ok = (in_line_b != 32'sd0)
               && (32'(in_query_col) >= 32'(w_eff)) && (32'(in_query_row) >= 32'(w_eff))
               && (32'(in_query_col) + 32'(w_eff) <= 32'(lw_eff))
               && (32'(in_query_row) + 32'(w_eff) <= 32'(lh_eff));
  assign d_sat  = (32'(acc_r) > 32'(SAD_CAP)) ? SAD_CAP : SAD_W'(acc_r);

  logic [35:0] lhs, rhs;
  assign lhs = {best_r, 16'h0000};
  assign rhs = 36'(ratio_r) * 36'(second_r);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      rd_v_r    <= 1'b0;
      x_r       <= '0;
      best_r    <= NONE_MARK;
      second_r  <= NONE_MARK;
      bcol_r    <= '0;
      brow_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      rd_v_r <= 1'b0;
      if (rd_v_r) acc_r <= acc_r + pair_sum;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && func == FUNC_QUERY) begin
            qc_r     <= in_query_col;
            qr_r     <= in_query_row;
            a_r      <= in_line_a;
            b_r      <= in_line_b;
            c_r      <= in_line_c;
            x_r      <= '0;
            best_r   <= NONE_MARK;
            second_r <= NONE_MARK;
            bcol_r   <= '0;
            brow_r   <= '0;
            cnt_r    <= '0;
            state_r  <= (start_ok && rw_eff != '0) ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          prod_r  <= DW'(a_r) * DW'($signed({1'b0, x_r}));
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= -num_sum;
          neg_r   <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          neg_r <= num_r[DW-1] ^ b_r[31];
          if (div_done) state_r <= S_CHK;
        end
        S_CHK: begin
          y_r <= div_q[RW-1:0];
          i_r <= '0;
          j_r <= '0;
          acc_r <= '0;
          state_r <= (y_ok && win_ok) ? S_SAD : S_NEXT;
        end
        S_SAD: begin
          rd_v_r <= 1'b1;
          if (j_r == two_w - 1'b1) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
            if (i_r == two_w - 1'b1) state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_UPD;
        S_UPD: begin
          if (cnt_r != 2'd3) cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd0 || d_sat < best_r) begin
            second_r <= best_r;
            best_r   <= d_sat;
            bcol_r   <= POS_W'(x_r);
            brow_r   <= POS_W'(y_r);
          end else if (cnt_r == 2'd1 || d_sat < second_r) begin
            second_r <= d_sat;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          x_r     <= x_r + 1'b1;
          state_r <= (x_r + 1'b1 == rw_eff) ? S_FIN : S_MUL;
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_found      <= (cnt_r >= 2'd2) && (lhs < rhs);
            out_ref_col    <= qc_r;
            out_ref_row    <= qr_r;
            out_match_col  <= ((cnt_r >= 2'd2) && (lhs < rhs)) ? bcol_r : '0;
            out_match_row  <= ((cnt_r >= 2'd2) && (lhs < rhs)) ? brow_r : '0;
            out_best_sad   <= best_r;
            out_second_sad <= second_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_epipolar_sad_patch_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_epipolar_sad_patch_matcher
// Self-checking bench for the epipolar SAD patch matcher. Both images are
// loaded once over a small region, and every later phase sets the registers
// while the block is idle so that no query reads outside that region, then
// sends directed and random queries mixed with stray writes. A scoreboard
// predicts every query result from its own copy of the images and registers
// and checks the results field by field, in order.
// ----------------------------------------------------------------------------
module tb_epipolar_sad_patch_matcher;
  import espm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_PAUSE = 100;
  localparam int unsigned LONG_HOLD   = 3000;

  typedef struct {
    func_t              func;
    logic [8:0]         pcol;
    logic [8:0]         prow;
    logic [23:0]        pval;
    logic [8:0]         qcol;
    logic [8:0]         qrow;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } word_t;

  typedef struct {
    logic        found;
    logic [8:0]  ref_col;
    logic [8:0]  ref_row;
    logic [8:0]  match_col;
    logic [8:0]  match_row;
    logic [19:0] best;
    logic [19:0] second;
  } match_t;

  // Holds the image copies, the registers and the queue of expected matches
  class match_scoreboard;
    bit [23:0]   left_px [0:262143];
    bit [23:0]   right_px [0:262143];
    int unsigned lw, lh, rw, rh, hw, ratio, chans;
    match_t      expected_q[$];
    int unsigned fails;

    function new();
      lw = 512; lh = 512; rw = 512; rh = 512;
      hw = 5; ratio = 52429; chans = 1; fails = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_LEFT_WIDTH:   lw = v[9:0];
        REG_LEFT_HEIGHT:  lh = v[9:0];
        REG_RIGHT_WIDTH:  rw = v[9:0];
        REG_RIGHT_HEIGHT: rh = v[9:0];
        REG_HALF_WINDOW:  hw = v[4:0];
        REG_RATIO:        ratio = v;
        REG_CHANNELS:     chans = v[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned patch_sad(int unsigned lx, int unsigned ly, int unsigned rx,
                                    int unsigned ry, int unsigned wh, int unsigned nch);
      longint unsigned acc;
      bit [23:0]       lp, rp;
      int unsigned     p, q;
      acc = 0;
      for (int unsigned i = 0; i < 2 * wh; i++) begin
        for (int unsigned j = 0; j < 2 * wh; j++) begin
          lp = left_px[((ly - wh + i) * 512 + (lx - wh + j)) % 262144];
          rp = right_px[((ry - wh + i) * 512 + (rx - wh + j)) % 262144];
          for (int unsigned k = 0; k < nch; k++) begin
            p = (lp >> (8 * k)) & 8'hFF;
            q = (rp >> (8 * k)) & 8'hFF;
            acc += (p > q) ? p - q : q - p;
          end
        end
      end
      return (acc > SAD_CAP) ? SAD_CAP : acc;
    endfunction

    // Scan the line across image two and keep the two smallest sums
    function match_t find_match(word_t w);
      match_t      r;
      int unsigned wh, nch, lwc, lhc, rwc, rhc, qc, qr, cnt, d;
      int unsigned best, second, bcol, brow;
      longint      a, b, c, num, y;
      qc = w.qcol; qr = w.qrow;
      a = longint'(w.a); b = longint'(w.b); c = longint'(w.c);
      wh = (hw == 0) ? 1 : (hw > 16) ? 16 : hw;
      nch = (chans == 0) ? 1 : (chans > 3) ? 3 : chans;
      lwc = (lw > 512) ? 512 : lw;
      lhc = (lh > 512) ? 512 : lh;
      rwc = (rw > 512) ? 512 : rw;
      rhc = (rh > 512) ? 512 : rh;
      best = NONE_MARK; second = NONE_MARK; bcol = 0; brow = 0; cnt = 0;
      if (b != 0 && qc >= wh && qr >= wh && qc + wh <= lwc && qr + wh <= lhc) begin
        for (int unsigned x = 0; x < rwc; x++) begin
          num = -(a * longint'(x) + c);
          y = num / b;
          if (y < 0 || y >= longint'(rhc)) continue;
          if (x < wh || y < wh || x + wh > rwc || y + wh > rhc) continue;
          d = patch_sad(qc, qr, x, int'(y), wh, nch);
          cnt++;
          if (cnt == 1 || d < best) begin
            second = best; best = d; bcol = x; brow = int'(y);
          end else if (cnt == 2 || d < second) begin
            second = d;
          end
        end
      end
      r.found = (cnt >= 2) &&
                (longint'(best) * 65536 < longint'(ratio) * longint'(second));
      r.ref_col = qc; r.ref_row = qr;
      r.match_col = r.found ? bcol : 0;
      r.match_row = r.found ? brow : 0;
      r.best = best; r.second = second;
      return r;
    endfunction

    // Note an accepted word: store pixels, predict queries
    function void note_word(word_t w);
      case (w.func)
        FUNC_WR_LEFT:  left_px[w.prow * 512 + w.pcol] = w.pval;
        FUNC_WR_RIGHT: right_px[w.prow * 512 + w.pcol] = w.pval;
        FUNC_QUERY:    expected_q.insert(expected_q.size(), find_match(w));
        default: ;
      endcase
    endfunction

    function void cmp(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp, act);
        fails++;
      end
    endfunction

    function void check_match(match_t r);
      match_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result word: ref %0d,%0d", $time, r.ref_col, r.ref_row);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      cmp("found", e.found, r.found);
      cmp("ref_col", e.ref_col, r.ref_col);
      cmp("ref_row", e.ref_row, r.ref_row);
      cmp("match_col", e.match_col, r.match_col);
      cmp("match_row", e.match_row, r.match_row);
      cmp("best_sad", e.best, r.best);
      cmp("second_sad", e.second, r.second);
    endfunction
  endclass

  logic               clk, rst_n;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid, in_stall;
  logic [1:0]         in_func;
  logic [POS_W-1:0]   in_pixel_col, in_pixel_row, in_query_col, in_query_row;
  logic [PIX_W-1:0]   in_pixel_value;
  logic signed [31:0] in_line_a, in_line_b, in_line_c;
  logic               out_valid, out_stall, out_found;
  logic [POS_W-1:0]   out_ref_col, out_ref_row, out_match_col, out_match_row;
  logic [SAD_W-1:0]   out_best_sad, out_second_sad;

  match_scoreboard sb;
  bit              send_quiet, recv_quiet, hold_req;
  int unsigned     stall_left;
  int unsigned     cycles;

  epipolar_sad_patch_matcher u_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_func, .in_pixel_col, .in_pixel_row, .in_pixel_value,
    .in_query_col, .in_query_row, .in_line_a, .in_line_b, .in_line_c,
    .out_valid, .out_stall, .out_found, .out_ref_col, .out_ref_row,
    .out_match_col, .out_match_row, .out_best_sad, .out_second_sad
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run on a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Take result words, stall at random, hold off long on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_match('{out_found, out_ref_col, out_ref_row, out_match_col,
                         out_match_row, out_best_sad, out_second_sad});
        stall_left = recv_quiet ? 0 : $urandom_range(0, 14);
      end
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word, wait for acceptance, then idle for a drawn gap
  task automatic send_word(word_t w);
    int unsigned gap;
    in_func <= w.func;
    in_pixel_col <= w.pcol; in_pixel_row <= w.prow; in_pixel_value <= w.pval;
    in_query_col <= w.qcol; in_query_row <= w.qrow;
    in_line_a <= w.a; in_line_b <= w.b; in_line_c <= w.c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_pixel(func_t f, int unsigned col, int unsigned row,
                             logic [23:0] v);
    word_t w;
    w = '{f, col, row, v, $urandom, $urandom, $urandom, $urandom, $urandom};
    send_word(w);
  endtask

  task automatic send_query(int unsigned qc, int unsigned qr, logic signed [31:0] a,
                            logic signed [31:0] b, logic signed [31:0] c);
    word_t w;
    w = '{FUNC_QUERY, $urandom, $urandom, $urandom, qc, qr, a, b, c};
    send_word(w);
  endtask

  // Wait until every expected match has come and the block is at rest
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Load image one at random and image two as a shifted noisy copy of it
  task automatic load_images(int unsigned shift);
    int unsigned lwc, lhc, rwc, rhc, src;
    logic [23:0] v;
    lwc = (sb.lw > 512) ? 512 : sb.lw;
    lhc = (sb.lh > 512) ? 512 : sb.lh;
    rwc = (sb.rw > 512) ? 512 : sb.rw;
    rhc = (sb.rh > 512) ? 512 : sb.rh;
    for (int unsigned r = 0; r < lhc; r++)
      for (int unsigned c = 0; c < lwc; c++)
        write_pixel(FUNC_WR_LEFT, c, r, $urandom);
    for (int unsigned r = 0; r < rhc; r++)
      for (int unsigned c = 0; c < rwc; c++) begin
        src = c + shift;
        if (src < lwc && r < lhc && $urandom_range(0, 7) != 0)
          v = sb.left_px[r * 512 + src];
        else
          v = $urandom;
        write_pixel(FUNC_WR_RIGHT, c, r, v);
      end
  endtask

  // One query with a line of a randomly chosen shape
  task automatic random_query();
    int unsigned wh, lwc, lhc, qc, qr, y0;
    logic signed [31:0] b;
    wh = (sb.hw == 0) ? 1 : (sb.hw > 16) ? 16 : sb.hw;
    lwc = (sb.lw > 512) ? 512 : sb.lw;
    lhc = (sb.lh > 512) ? 512 : sb.lh;
    qc = (lwc >= 2 * wh) ? $urandom_range(wh, lwc - wh) : $urandom_range(0, 511);
    qr = (lhc >= 2 * wh) ? $urandom_range(wh, lhc - wh) : $urandom_range(0, 511);
    y0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : qr;
    b = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_query(qc, qr, 0, b, -b * y0);
      4:          send_query(qc, qr, $urandom, 0, $urandom);
      5, 6:       send_query(qc, qr, $urandom, $urandom, $urandom);
      7:          send_query($urandom_range(0, 511), $urandom_range(0, 511), 0, b, -b * y0);
      default:    send_query(qc, qr, $urandom_range(0, 40000) - 20000, b,
                             -b * y0 + $urandom_range(0, 65535));
    endcase
  endtask

  // Stray writes anywhere in the stores and unused codes
  task automatic noise_word();
    word_t w;
    w = '{func_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom};
    if (w.func == FUNC_QUERY) w.func = FUNC_NONE;
    send_word(w);
  endtask

  task automatic set_all(int unsigned lw, int unsigned lh, int unsigned rw,
                         int unsigned rh, int unsigned hw, int unsigned ratio,
                         int unsigned ch);
    write_reg(REG_LEFT_WIDTH, lw);
    write_reg(REG_LEFT_HEIGHT, lh);
    write_reg(REG_RIGHT_WIDTH, rw);
    write_reg(REG_RIGHT_HEIGHT, rh);
    write_reg(REG_HALF_WINDOW, hw);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_CHANNELS, ch);
  endtask

  initial begin
    int unsigned wh;
    sb = new();
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0; cfg_index <= REG_LEFT_WIDTH; cfg_wdata <= '0;
    in_valid <= 1'b0; in_func <= FUNC_NONE;
    in_pixel_col <= '0; in_pixel_row <= '0; in_pixel_value <= '0;
    in_query_col <= '0; in_query_row <= '0;
    in_line_a <= '0; in_line_b <= '0; in_line_c <= '0;
    out_stall <= 1'b0;
    stall_left = 0; cycles = 0; hold_req = 1'b0;
    send_quiet = 1'b0; recv_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: only queries whose window cannot fit image one
    send_query(0, 0, 0, 32'sd65536, 0);
    send_query(511, 4, 32'sh7FFFFFFF, 0, 32'sh80000000);
    drain();

    // Directed: small images, three channels, field extremes, zero b, unused code
    set_all(4, 4, 6, 4, 2, 52429, 3);
    load_images(1);
    send_query(2, 2, 0, 32'sd65536, -32'sd131072);
    send_query(2, 2, 0, -32'sd65536, 32'sd131072);
    send_query(1, 2, 0, 32'sd65536, -32'sd131072);
    send_query(2, 2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    send_query(2, 2, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    send_query(2, 2, 32'sd5000, 0, 32'sd0);
    send_query(2, 2, 32'sd16384, -32'sd65536, 32'sd131072);
    send_query(511, 511, 0, 32'sd65536, -32'sd131072);
    write_pixel(FUNC_WR_LEFT, 511, 511, 24'hFFFFFF);
    write_pixel(FUNC_WR_RIGHT, 511, 511, 24'h000000);
    write_pixel(FUNC_NONE, 3, 3, 24'hA5A5A5);
    send_query(2, 2, 0, 32'sd65536, -32'sd131072);
    drain();

    // Largest window (register above range): fits image one, no candidate
    set_all(32, 32, 8, 32, 31, 65535, 3);
    send_query(16, 16, 0, 32'sd65536, -32'sd1048576);
    send_query(16, 16, 32'sd1, 32'sd65536, -32'sd1048576);
    drain();

    // Sizes above range saturate, smallest window, level lines
    set_all(1023, 1023, 6, 1023, 1, 65535, 1);
    send_query(2, 1, 0, 32'sd65536, -32'sd65536);
    send_query(3, 2, 0, -32'sd65536, 32'sd131072);
    drain();

    // All registers at zero: no window fits anywhere
    set_all(0, 0, 0, 0, 0, 0, 0);
    send_query(0, 0, 0, 32'sd65536, 0);
    send_query(5, 5, 0, 32'sd65536, -32'sd327680);
    drain();

    // Random phases inside the loaded region, one under a long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      wh = $urandom_range(1, 2);
      set_all(2 * wh + $urandom_range(0, 4 - 2 * wh), 2 * wh + $urandom_range(0, 4 - 2 * wh),
              2 * wh + $urandom_range(0, 6 - 2 * wh), 2 * wh + $urandom_range(0, 4 - 2 * wh),
              wh, (ph == 1) ? 0 : $urandom_range(30000, 65535), $urandom_range(1, 3));
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 9) == 0) noise_word();
        random_query();
      end
      drain();
    end

    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
